// ===== src/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/tbc_pkg.sv =====
// shared widths, stage types and a helper function for the coverage block
// no dependencies
`default_nettype none
package tbc_pkg;
  localparam int COORD_BITS       = 12;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int FIELD_W = 12;
  localparam int WGT_W   = 24;
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int NUM_W   = CROSS_W + 1 + WEIGHT_FRAC_BITS;
  localparam int QUO_W   = WGT_W + 1;
  localparam int EXT_W   = NUM_W + QUO_W + 1;
  localparam int FIN_W   = QUO_W + 2;
  localparam int IN_W    = 96;
  localparam int OUT_W   = 128;
  localparam int LANES   = 3;

  typedef struct packed {
    logic [FIELD_W-1:0] left;
    logic [FIELD_W-1:0] top;
    logic [FIELD_W-1:0] width;
    logic [FIELD_W-1:0] height;
    logic               covered;
    logic               degen;
    logic [LANES-1:0]   neg;
    logic [LANES-1:0]   ovf;
  } side_t;

  typedef struct packed {
    logic [LANES-1:0][NUM_W-1:0] rem;
    logic [LANES-1:0][QUO_W-1:0] quo;
    logic [CROSS_W-1:0]          den;
    side_t                       side;
  } div_t;

  function automatic logic [WGT_W-1:0] sat_wgt(input logic signed [FIN_W-1:0] v);
    logic signed [FIN_W-1:0] hi;
    logic signed [FIN_W-1:0] lo;
    hi = FIN_W'((64'sd1 <<< (WGT_W - 1)) - 64'sd1);
    lo = -FIN_W'(64'sd1 <<< (WGT_W - 1));
    if (v > hi) return hi[WGT_W-1:0];
    if (v < lo) return lo[WGT_W-1:0];
    return v[WGT_W-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== src/tbc_front.sv =====
// front end: box, edge differences, cross products, cross terms, divider set-up
// depends on tbc_pkg
`default_nettype none
module tbc_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [tbc_pkg::IN_W-1:0] in_data,
  output logic                      out_valid,
  output tbc_pkg::div_t             out_item
);
  import tbc_pkg::*;

  logic [COORD_BITS-1:0] x0, y0, x1, y1, x2, y2, px, py, lx, hx, ly, hy;
  logic [3:0] v_r;

  // stage 1 registers
  logic signed [DIFF_W-1:0] ax_r, bx_r, cx_r, ay_r, by_r, cy_r;
  logic [COORD_BITS-1:0] lx1_r, ly1_r, wx1_r, wy1_r;
  // stage 2
  logic signed [PROD_W-1:0] p_r [6];
  logic [COORD_BITS-1:0] lx2_r, ly2_r, wx2_r, wy2_r;
  // stage 3
  logic signed [CROSS_W-1:0] c0_r, c1_r, c2_r;
  logic [COORD_BITS-1:0] lx3_r, ly3_r, wx3_r, wy3_r;
  // stage 4
  div_t item_r, item_nxt;

  assign x0 = COORD_BITS'(in_data[11:0]);
  assign y0 = COORD_BITS'(in_data[23:12]);
  assign x1 = COORD_BITS'(in_data[35:24]);
  assign y1 = COORD_BITS'(in_data[47:36]);
  assign x2 = COORD_BITS'(in_data[59:48]);
  assign y2 = COORD_BITS'(in_data[71:60]);
  assign px = COORD_BITS'(in_data[83:72]);
  assign py = COORD_BITS'(in_data[95:84]);

  always_comb begin
    lx = (x0 < x1) ? x0 : x1;  lx = (lx < x2) ? lx : x2;
    hx = (x0 > x1) ? x0 : x1;  hx = (hx > x2) ? hx : x2;
    ly = (y0 < y1) ? y0 : y1;  ly = (ly < y2) ? ly : y2;
    hy = (y0 > y1) ? y0 : y1;  hy = (hy > y2) ? hy : y2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r  <= $signed({1'b0, x2}) - $signed({1'b0, x0});
      bx_r  <= $signed({1'b0, x1}) - $signed({1'b0, x0});
      cx_r  <= $signed({1'b0, x0}) - $signed({1'b0, px});
      ay_r  <= $signed({1'b0, y2}) - $signed({1'b0, y0});
      by_r  <= $signed({1'b0, y1}) - $signed({1'b0, y0});
      cy_r  <= $signed({1'b0, y0}) - $signed({1'b0, py});
      lx1_r <= lx;
      ly1_r <= ly;
      wx1_r <= hx - lx;
      wy1_r <= hy - ly;

      p_r[0] <= bx_r * cy_r;
      p_r[1] <= cx_r * by_r;
      p_r[2] <= cx_r * ay_r;
      p_r[3] <= ax_r * cy_r;
      p_r[4] <= ax_r * by_r;
      p_r[5] <= bx_r * ay_r;
      lx2_r <= lx1_r; ly2_r <= ly1_r; wx2_r <= wx1_r; wy2_r <= wy1_r;

      c0_r <= CROSS_W'(p_r[0]) - CROSS_W'(p_r[1]);
      c1_r <= CROSS_W'(p_r[2]) - CROSS_W'(p_r[3]);
      c2_r <= CROSS_W'(p_r[4]) - CROSS_W'(p_r[5]);
      lx3_r <= lx2_r; ly3_r <= ly2_r; wx3_r <= wx2_r; wy3_r <= wy2_r;

      item_r <= item_nxt;
    end
  end

  always_comb begin
    logic signed [CROSS_W:0]   s01;
    logic signed [CROSS_W+1:0] e;
    logic [CROSS_W:0]          mag0, mag1, mag01;
    s01 = (CROSS_W+1)'(c0_r) + (CROSS_W+1)'(c1_r);
    e   = (CROSS_W+2)'(c2_r) - (CROSS_W+2)'(s01);
    mag0  = c0_r[CROSS_W-1] ? (CROSS_W+1)'(-(CROSS_W+1)'(c0_r)) : (CROSS_W+1)'(c0_r);
    mag1  = c1_r[CROSS_W-1] ? (CROSS_W+1)'(-(CROSS_W+1)'(c1_r)) : (CROSS_W+1)'(c1_r);
    mag01 = s01[CROSS_W] ? (CROSS_W+1)'(-s01) : (CROSS_W+1)'(s01);
    item_nxt.den = c2_r[CROSS_W-1] ? CROSS_W'(-c2_r) : CROSS_W'(c2_r);
    // lane 0: c0, lane 1: c1, lane 2: c0 plus c1
    item_nxt.rem[0] = NUM_W'(mag0)  << WEIGHT_FRAC_BITS;
    item_nxt.rem[1] = NUM_W'(mag1)  << WEIGHT_FRAC_BITS;
    item_nxt.rem[2] = NUM_W'(mag01) << WEIGHT_FRAC_BITS;
    item_nxt.quo    = '0;
    item_nxt.side.left   = FIELD_W'(lx3_r);
    item_nxt.side.top    = FIELD_W'(ly3_r);
    item_nxt.side.width  = FIELD_W'(wx3_r);
    item_nxt.side.height = FIELD_W'(wy3_r);
    item_nxt.side.degen  = (c2_r == '0);
    item_nxt.side.neg[0] = c0_r[CROSS_W-1] ^ c2_r[CROSS_W-1];
    item_nxt.side.neg[1] = c1_r[CROSS_W-1] ^ c2_r[CROSS_W-1];
    item_nxt.side.neg[2] = s01[CROSS_W] ^ c2_r[CROSS_W-1];
    for (int j = 0; j < LANES; j++) begin
      item_nxt.side.ovf[j] = EXT_W'(item_nxt.rem[j]) >= (EXT_W'(item_nxt.den) << QUO_W);
    end
    if (c2_r == '0) begin
      item_nxt.side.covered = 1'b0;
    end else if (!c2_r[CROSS_W-1]) begin
      item_nxt.side.covered = !c0_r[CROSS_W-1] && !c1_r[CROSS_W-1] && !e[CROSS_W+1];
    end else begin
      item_nxt.side.covered = (c0_r <= 0) && (c1_r <= 0) && (e <= 0);
    end
  end

  assign out_valid = v_r[3];
  assign out_item  = item_r;
endmodule
`default_nettype wire

// ===== src/tbc_div.sv =====
// restoring divider pipeline, one quotient bit per stage for all three lanes
// depends on tbc_pkg
`default_nettype none
module tbc_div (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  tbc_pkg::div_t in_item,
  output logic       out_valid,
  output tbc_pkg::div_t out_item
);
  import tbc_pkg::*;

  div_t st_r [QUO_W+1];
  logic [QUO_W:0] v_r;

  assign st_r[0] = in_item;
  assign v_r[0]  = in_valid;

  for (genvar g = 0; g < QUO_W; g++) begin : g_step
    localparam int SH = QUO_W - 1 - g;
    div_t nxt;
    always_comb begin
      logic [EXT_W-1:0] dsh;
      dsh = EXT_W'(st_r[g].den) << SH;
      nxt = st_r[g];
      for (int j = 0; j < LANES; j++) begin
        if (EXT_W'(st_r[g].rem[j]) >= dsh) begin
          nxt.rem[j]     = st_r[g].rem[j] - NUM_W'(dsh);
          nxt.quo[j][SH] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else if (en) begin
        v_r[g+1] <= v_r[g];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g+1] <= nxt;
      end
    end
  end

  assign out_valid = v_r[QUO_W];
  assign out_item  = st_r[QUO_W];
endmodule
`default_nettype wire

// ===== src/triangle_barycentric_coverage.sv =====
// Triangle bounding box and barycentric coverage, one pixel per transaction.
// Fully pipelined: a new transaction is taken every cycle unless the output
// stalls; a result passes through four front stages, 25 divider stages, one
// sign and saturation stage and the output register. The whole pipeline advances
// together and freezes while the output register holds an untaken result.
// Depends on tbc_pkg, tbc_front and tbc_div.
`default_nettype none
module triangle_barycentric_coverage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, pixel_x, pixel_y
  input  wire logic [tbc_pkg::IN_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // box_left, box_top, box_width, box_height, weight_a, weight_b, weight_c,
  // inside_res, degenerate, zero fill
  output logic [tbc_pkg::OUT_W-1:0]          out_tdata
);
  import tbc_pkg::*;

  logic  en;
  logic  f_valid, d_valid;
  div_t  f_item, d_item;
  logic  fin_valid_r;
  div_t  fin_r;
  logic  out_valid_r;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  // the whole pipe moves unless a finished result is waiting
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  tbc_front u_front (
    .clk, .rst_n, .en,
    .in_valid (in_tvalid && in_tready),
    .in_data  (in_tdata),
    .out_valid(f_valid),
    .out_item (f_item)
  );

  tbc_div u_div (
    .clk, .rst_n, .en,
    .in_valid (f_valid),
    .in_item  (f_item),
    .out_valid(d_valid),
    .out_item (d_item)
  );

  // stage after the divider: holds quotient magnitudes before signing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (en) begin
      fin_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= d_item;
    end
  end

  always_comb begin
    logic signed [FIN_W-1:0] q [LANES];
    logic signed [FIN_W-1:0] one;
    logic [QUO_W-1:0]        m;
    logic [WGT_W-1:0]        wa, wb, wc;
    one = FIN_W'(64'sd1 <<< WEIGHT_FRAC_BITS);
    for (int j = 0; j < LANES; j++) begin
      // quotient beyond the divider range is clamped, saturation follows
      m    = fin_r.side.ovf[j] ? '1 : fin_r.quo[j];
      q[j] = fin_r.side.neg[j] ? -$signed(FIN_W'(m)) : $signed(FIN_W'(m));
    end
    if (fin_r.side.degen) begin
      // zero area: every weight is minus one
      wa = sat_wgt(-one);
      wb = wa;
      wc = wa;
    end else begin
      wa = sat_wgt(one - q[2]);
      wb = sat_wgt(q[1]);
      wc = sat_wgt(q[0]);
    end
    out_data_nxt = {6'd0, fin_r.side.degen, fin_r.side.covered, wc, wb, wa,
                    fin_r.side.height, fin_r.side.width, fin_r.side.top,
                    fin_r.side.left};
  end

  // output register, parts the pipe from the downstream side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fin_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
endmodule
`default_nettype wire

// ===== src/tbc_checker.sv =====
// port-level checks for the coverage block, bound to the top level
// depends on assert_macros.svh and tbc_pkg
`default_nettype none
`include "assert_macros.svh"
module tbc_checker (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_tready,
  input wire logic                     out_tvalid,
  input wire logic                     out_tready,
  input wire logic [tbc_pkg::OUT_W-1:0] out_tdata
);
  logic [23:0] wgt_a, wgt_b, wgt_c;
  logic        dgn, cov;

  assign wgt_a = out_tdata[71:48];
  assign wgt_b = out_tdata[95:72];
  assign wgt_c = out_tdata[119:96];
  assign cov   = out_tdata[120];
  assign dgn   = out_tdata[121];

  // a zero-area triangle never covers the pixel
  `ASSERT_IMPL(a_degen_out, clk, rst_n, out_tvalid && dgn, !cov)
  // degenerate results carry three equal weights
  `ASSERT_IMPL(a_degen_wgt, clk, rst_n, out_tvalid && dgn, (wgt_a == wgt_b) && (wgt_b == wgt_c))
  // a stalled result holds
  `ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // input is refused only while a result waits untaken
  `ASSERT_IMPL(a_ready, clk, rst_n, !in_tready, out_tvalid && !out_tready)
endmodule
bind triangle_barycentric_coverage tbc_checker u_tbc_checker (.*);
`default_nettype wire
